### sv/ptu64_pkg.sv
// ----------------------------------------------------------------------------
// ptu64_pkg
// shared types, tables and constants for the 64-bit primality tester
// ----------------------------------------------------------------------------
package ptu64_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned CntW    = 6;
  localparam int unsigned NumSmall = 11;
  localparam int unsigned NumBases = 7;
  localparam int unsigned PidxW   = 4;
  localparam int unsigned BidxW   = 3;
  localparam int unsigned RemW    = 6;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIAL,
    ST_SPLIT,
    ST_BASE_START,
    ST_BASE_RED,
    ST_POW,
    ST_MUL,
    ST_WIT,
    ST_SQ_LOOP,
    ST_SQ_CHK,
    ST_NEXT_BASE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MUL_RES,
    MUL_SQB,
    MUL_SQX
  } mul_kind_t;

  function automatic logic [RemW-1:0] small_prime(input logic [PidxW-1:0] idx);
    logic [RemW-1:0] p;
    case (idx)
      4'd0:    p = 6'd3;
      4'd1:    p = 6'd5;
      4'd2:    p = 6'd7;
      4'd3:    p = 6'd11;
      4'd4:    p = 6'd13;
      4'd5:    p = 6'd17;
      4'd6:    p = 6'd19;
      4'd7:    p = 6'd23;
      4'd8:    p = 6'd29;
      4'd9:    p = 6'd31;
      default: p = 6'd37;
    endcase
    return p;
  endfunction

  function automatic word_t mr_base(input logic [BidxW-1:0] idx);
    word_t b;
    case (idx)
      3'd0:    b = 64'd2;
      3'd1:    b = 64'd325;
      3'd2:    b = 64'd9375;
      3'd3:    b = 64'd28178;
      3'd4:    b = 64'd450775;
      3'd5:    b = 64'd9780504;
      default: b = 64'd1795265022;
    endcase
    return b;
  endfunction

endpackage

### sv/primality_test_u64_top.sv
// ----------------------------------------------------------------------------
// primality_test_u64_top
// deterministic miller-rabin primality test for unsigned 64-bit numbers
// ----------------------------------------------------------------------------
//  channel  signals                          direction
//  in       in_valid, in_stall, candidate    request in
//  out      out_valid, out_stall, prime_flag request out
//
//  one request at a time; trivial values go straight to the finish state
//  trial division: bit-serial remainder, up to 11 small primes
//  miller-rabin: each modular product is formed in the bit-serial
//  shift-add multiplier, up to 126 products per base, 7 bases
//  reset is synchronous and idles the block
//  a new request is taken while a finished result waits on out_stall
// ----------------------------------------------------------------------------
module primality_test_u64_top
  import ptu64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        prime_flag
);

  state_t              state, state_next;
  mul_kind_t           kind;
  word_t               n, d, e, res, b, mx, sh, acc;
  logic [CntW-1:0]     cnt, s, sq_i;
  logic [PidxW-1:0]    pidx;
  logic [BidxW-1:0]    bidx;
  logic [RemW-1:0]     rem;
  logic                flag;

  logic                in_acc, out_free, cnt_last;
  logic [RemW:0]       trem_sum;
  logic [RemW-1:0]     trem;
  logic [WordW:0]      n_ext, dbl, sum, red_t;
  word_t               a1, a2, acc_mul, red, n_m1;
  logic                cand_trivial, cand_flag;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cnt_last = (cnt == CntW'(WordW - 1));
  assign n_ext    = {1'b0, n};
  assign n_m1     = n - 64'd1;

  // trial division digit step
  assign trem_sum = {rem, sh[WordW-1]};
  assign trem     = (trem_sum >= {1'b0, small_prime(pidx)}) ?
                    RemW'(trem_sum - {1'b0, small_prime(pidx)}) : RemW'(trem_sum);

  // modular multiply step: double, then add on a set bit
  assign dbl     = {acc, 1'b0};
  assign a1      = (dbl >= n_ext) ? WordW'(dbl - n_ext) : WordW'(dbl);
  assign sum     = {1'b0, a1} + {1'b0, mx};
  assign a2      = (sum >= n_ext) ? WordW'(sum - n_ext) : WordW'(sum);
  assign acc_mul = sh[WordW-1] ? a2 : a1;

  // base reduction step
  assign red_t = {acc, sh[WordW-1]};
  assign red   = (red_t >= n_ext) ? WordW'(red_t - n_ext) : WordW'(red_t);

  // trivial candidates
  always_comb begin
    cand_trivial = 1'b0;
    cand_flag    = 1'b0;
    if (candidate < 64'd2) begin
      cand_trivial = 1'b1;
    end else if (candidate == 64'd2 || candidate == 64'd3) begin
      cand_trivial = 1'b1;
      cand_flag    = 1'b1;
    end else if (!candidate[0]) begin
      cand_trivial = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = cand_trivial ? ST_FINISH : ST_TRIAL;
      end
      ST_TRIAL: begin
        if (cnt_last) begin
          if (n == {58'd0, small_prime(pidx)} || trem == '0) state_next = ST_FINISH;
          else if (pidx == PidxW'(NumSmall - 1)) state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (d[0]) state_next = ST_BASE_START;
      end
      ST_BASE_START: state_next = ST_BASE_RED;
      ST_BASE_RED: begin
        if (cnt_last) state_next = (red == '0) ? ST_NEXT_BASE : ST_POW;
      end
      ST_POW: state_next = (e == '0) ? ST_WIT : ST_MUL;
      ST_MUL: begin
        if (cnt_last) begin
          if (kind == MUL_SQB) state_next = ST_POW;
          else if (kind == MUL_SQX) state_next = ST_SQ_CHK;
        end
      end
      ST_WIT: state_next = (res == 64'd1 || res == n_m1) ? ST_NEXT_BASE : ST_SQ_LOOP;
      ST_SQ_LOOP: state_next = (sq_i >= s) ? ST_FINISH : ST_MUL;
      ST_SQ_CHK: state_next = (res == n_m1) ? ST_NEXT_BASE : ST_SQ_LOOP;
      ST_NEXT_BASE: begin
        state_next = (bidx == BidxW'(NumBases - 1)) ? ST_FINISH : ST_BASE_START;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          n    <= candidate;
          sh   <= candidate;
          flag <= cand_flag;
          pidx <= '0;
          rem  <= '0;
          cnt  <= '0;
        end
      end
      ST_TRIAL: begin
        rem <= trem;
        sh  <= {sh[WordW-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt_last) begin
          flag <= (n == {58'd0, small_prime(pidx)});
          pidx <= pidx + 1'b1;
          sh   <= n;
          rem  <= '0;
          d    <= n_m1;
          s    <= '0;
        end
      end
      ST_SPLIT: begin
        bidx <= '0;
        if (!d[0]) begin
          d <= {1'b0, d[WordW-1:1]};
          s <= s + 1'b1;
        end
      end
      ST_BASE_START: begin
        sh  <= mr_base(bidx);
        acc <= '0;
        cnt <= '0;
      end
      ST_BASE_RED: begin
        acc <= red;
        sh  <= {sh[WordW-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt_last) begin
          b   <= red;
          res <= 64'd1;
          e   <= d;
        end
      end
      ST_POW: begin
        acc <= '0;
        cnt <= '0;
        if (e[0]) begin
          mx   <= b;
          sh   <= res;
          kind <= MUL_RES;
        end else begin
          mx   <= b;
          sh   <= b;
          kind <= MUL_SQB;
        end
      end
      ST_MUL: begin
        acc <= acc_mul;
        sh  <= {sh[WordW-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt_last) begin
          unique case (kind)
            MUL_RES: begin
              res  <= acc_mul;
              mx   <= b;
              sh   <= b;
              acc  <= '0;
              kind <= MUL_SQB;
            end
            MUL_SQB: begin
              b <= acc_mul;
              e <= {1'b0, e[WordW-1:1]};
            end
            MUL_SQX: res <= acc_mul;
            default: res <= acc_mul;
          endcase
        end
      end
      ST_WIT: sq_i <= CntW'(1);
      ST_SQ_LOOP: begin
        if (sq_i >= s) begin
          flag <= 1'b0;
        end else begin
          mx   <= res;
          sh   <= res;
          acc  <= '0;
          cnt  <= '0;
          kind <= MUL_SQX;
        end
      end
      ST_SQ_CHK: sq_i <= sq_i + 1'b1;
      ST_NEXT_BASE: begin
        bidx <= bidx + 1'b1;
        flag <= 1'b1;
      end
      ST_FINISH: begin
        if (out_free) prime_flag <= flag;
      end
      default: ;
    endcase
  end

  a_mul_operands_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> (mx < n) && (acc < n))
    else $error("multiplier operand not reduced");

  a_split_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_SPLIT |-> d != '0)
    else $error("odd part of n-1 is zero");

  a_two_is_prime: assert property (@(posedge clk) disable iff (rst)
    (in_acc && candidate == 64'd2) |=> (state == ST_FINISH) && flag)
    else $error("two not flagged prime");

  a_sq_loop_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQ_CHK |-> (sq_i < s) && (s != '0))
    else $error("squaring loop past s");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the 64-bit primality tester against a miller-rabin predictor
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] candidate;
  logic        out_valid;
  logic        out_stall;
  logic        prime_flag;

  bit          flag_q[$];
  int          n_err;
  int          n_req;
  int          n_res;
  int          idle_cnt;
  bit          hold_out;
  bit          rand_stall;

  localparam int unsigned IdleLimit = 2000000;

  primality_test_u64_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .out_valid(out_valid), .out_stall(out_stall),
    .prime_flag(prime_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y,
                                          logic [63:0] m);
    logic [64:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[63:0];
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y,
                                          logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = mod_add(acc, acc, m);
      if (y[i]) acc = mod_add(acc, x, m);
    end
    return acc;
  endfunction

  function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e,
                                          logic [63:0] m);
    logic [63:0] r;
    r = 64'd1;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic bit exp_prime(logic [63:0] n);
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] bases[7];
    int          sp[11];
    int          s;
    bit          ok;
    bases = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
              64'd1795265022};
    sp = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    if (n < 2) return 0;
    if (n == 2 || n == 3) return 1;
    if (!n[0]) return 0;
    foreach (sp[k]) begin
      if (n == sp[k]) return 1;
      if (n % sp[k] == 0) return 0;
    end
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    foreach (bases[k]) begin
      a = bases[k] % n;
      if (a != 0) begin
        x = mod_pow(a, d, n);
        ok = (x == 1 || x == n - 1);
        for (int i = 1; i < s && !ok; i++) begin
          x = mod_mul(x, x, n);
          if (x == n - 1) ok = 1;
        end
        if (!ok) return 0;
      end
    end
    return 1;
  endfunction

  task automatic send_request(logic [63:0] n, bit gap);
    int w;
    w = gap ? $urandom_range(0, 17) : 0;
    if (w != 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= n;
    flag_q.push_back(exp_prime(n));
    do @(posedge clk); while (in_stall);
    n_req++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (flag_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_res <= n_res + 1;
      if (flag_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result prime_flag=%0b", prime_flag);
      end else begin
        if (flag_q[0] !== prime_flag) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected %0b got %0b", flag_q[0], prime_flag);
        end
        void'(flag_q.pop_front());
      end
    end
  end

  // receiver stall
  initial begin
    int w;
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end else if (!rand_stall) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        w = $urandom_range(0, 17);
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [63:0] v[$];
    v = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd37, 64'd39, 64'd41,
          64'd325, 64'd9375, 64'd2047, 64'd3215031751, 64'd1795265022,
          64'd1795265023, 64'd1000000007, 64'd3825123056546413051,
          64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000, 64'd1371,
          64'd49, 64'd1369};
    foreach (v[i]) send_request(v[i], 1'b0);
    wait_drain();
  endtask

  task automatic test_random();
    logic [63:0] n;
    for (int i = 0; i < 70; i++) begin
      case ($urandom_range(0, 3))
        0:       n = {$urandom, $urandom};
        1:       n = {$urandom, $urandom} | 64'd1;
        2:       n = $urandom_range(0, 5000);
        default: n = {32'd0, $urandom} | 64'd1;
      endcase
      send_request(n, 1'b1);
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_request(64'd1000 + 2 * i + 1, 1'b0);
    join
    wait_drain();
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    candidate  <= '0;
    hold_out   = 1'b0;
    rand_stall = 1'b0;
    n_err = 0;
    n_req = 0;
    n_res = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    rand_stall = 1'b1;
    test_random();
    $display("%0d requests sent, %0d results checked: edge values, primes,", n_req, n_res);
    $display("composites, random values and output back-pressure");
    if (n_err == 0 && flag_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/ptu64_pkg.sv
sv/primality_test_u64_top.sv
dv/testbench.sv
